// ===== hdl/h3x_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the H3 XOR hash block.
// No dependencies; used by h3x_tbl, h3x_ofifo and h3_xor_hash.

package h3x_pkg;

  // Field widths fixed by the word formats.
  localparam int CFG_W        = 9;
  localparam int WORD_IDX_W   = 8;
  localparam int TABLE_WORD_W = 32;
  localparam int DATA_BYTE_W  = 8;
  localparam int OUT_HASH_W   = 32;

  // One table bank per bit of a key byte.
  localparam int BANKS  = 8;
  localparam int BANK_W = 3;

  // Parameter defaults.
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int HASH_WIDTH_DEF  = 32;

  // Result queue between the accumulator and the output port.
  localparam int OFIFO_DEPTH = 4;
  localparam int OFIFO_PTR_W = 2;
  localparam int OFIFO_CNT_W = 3;

  // Item kinds carried in in_tuser.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_HASH = 1'b1;

  typedef struct packed {
    logic                  too_long;
    logic [OUT_HASH_W-1:0] hash;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/h3x_tbl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Random word table of the H3 hash, split into eight banks by the low index bits.
// Depends on h3x_pkg.

module h3x_tbl
  import h3x_pkg::*;
#(
  parameter int DEPTH = TABLE_DEPTH_DEF,
  parameter int WIDTH = 32,
  localparam int IDX_W = $clog2(DEPTH),
  localparam int ROWS  = DEPTH / BANKS,
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [IDX_W-1:0]            wr_addr,
  input  wire logic [WIDTH-1:0]            wr_data,
  input  wire logic                        rd_en,
  input  wire logic [ROW_W-1:0]            rd_row,
  output logic      [BANKS-1:0][WIDTH-1:0] rd_data
);

  logic [BANK_W-1:0] wr_bank;
  logic [ROW_W-1:0]  wr_row;

  assign wr_bank = wr_addr[BANK_W-1:0];
  assign wr_row  = ROW_W'(wr_addr >> BANK_W);

  // Every bank is read at the same row, so one key byte costs one access per bank.
  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    logic [WIDTH-1:0] mem [ROWS];

    always_ff @(posedge clk) begin
      if (wr_en && (wr_bank == BANK_W'(b))) begin
        mem[wr_row] <= wr_data;
      end
      if (rd_en) begin
        rd_data[b] <= mem[rd_row];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/h3x_ofifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Small result queue that decouples the hash pipeline from the output port.
// Depends on h3x_pkg.

module h3x_ofifo
  import h3x_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire res_t                   push_data,
  input  wire logic                   pop_ready,
  output logic                        pop_valid,
  output res_t                        pop_data,
  output logic [OFIFO_CNT_W-1:0]      count
);

  res_t                   slot_r [OFIFO_DEPTH];
  logic [OFIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OFIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OFIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                   pop;

  assign pop_valid = (cnt_r != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = slot_r[rd_ptr_r];
  assign count     = cnt_r;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + OFIFO_CNT_W'(push) - OFIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/h3_xor_hash.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Top level of the H3 universal XOR hash over byte keys.
// Depends on h3x_pkg, h3x_tbl (banked word table) and h3x_ofifo (result queue).
//
//   Channel   Direction  Handshake             Contents
//   in_       slave      tvalid/tready         tdata: word_index, table_word, data_byte;
//                                              tuser: op; tlast: last_byte
//   out_      master     tvalid/tready         tdata: hash_value; tuser: too_long
//   cfg_      write      wr_en (no back-pressure) wr_data: table_words
//
// A new word may be accepted on every cycle while in_tready is high. The
// table is held in eight banks, one per bit of a key byte, so a whole byte is
// served by a single read of all banks, and the XOR into the accumulator
// happens in the following cycle. A result passes through the second stage
// and the result queue before it leaves the output. Reset clears the
// accumulator, the key position, the overflow flag, table_words and the result
// queue; the table itself is not cleared and must be loaded before use.
// in_tready drops only when the four-entry result queue, together with a
// result still in flight, could not take one more.

module h3_xor_hash
  import h3x_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int HASH_WIDTH  = HASH_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input words.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // [7:0] word_index, [39:8] table_word, [47:40] data_byte
  input  wire logic        in_tuser,   // [0] op
  input  wire logic        in_tlast,   // last_byte
  // Results.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] hash_value
  output logic             out_tuser,  // [0] too_long
  // Configuration.
  input  wire logic        cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data
);

  // Index and position widths follow the table depth (a power of two, at
  // least eight). Stored words are cut to the hash width, at most the 32-bit
  // table word, as only those bits ever reach the result.
  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int POS_W   = IDX_W + 1;
  localparam int ROWS    = TABLE_DEPTH / BANKS;
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CMP_W   = ((POS_W > CFG_W) ? POS_W : CFG_W) + 1;
  localparam int STORE_W = (HASH_WIDTH < TABLE_WORD_W) ? HASH_WIDTH : TABLE_WORD_W;

  // Unpacked input fields.
  logic [WORD_IDX_W-1:0]   word_index;
  logic [TABLE_WORD_W-1:0] table_word;
  logic [DATA_BYTE_W-1:0]  data_byte;

  assign word_index = in_tdata[7:0];
  assign table_word = in_tdata[39:8];
  assign data_byte  = in_tdata[47:40];

  // Configuration and key-tracking state.
  logic [CFG_W-1:0] table_words_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             ovf_r, ovf_nxt;
  logic [STORE_W-1:0] acc_r, acc_nxt;

  // Second stage: the byte whose table words are being read.
  logic                   s1_valid_r;
  logic                   s1_xor_r;
  logic                   s1_last_r;
  logic                   s1_ovf_r;
  logic [DATA_BYTE_W-1:0] s1_byte_r;

  logic in_fire, is_load, is_hash;
  logic load_in_range;
  logic [CMP_W-1:0] words_in_use;
  logic ovf_now, do_xor;
  logic [ROW_W-1:0] rd_row;
  logic [BANKS-1:0][STORE_W-1:0] rd_data;
  logic [STORE_W-1:0] sel_xor, acc_x;
  logic s1_res;
  res_t push_data, pop_data;
  logic [OFIFO_CNT_W-1:0] fifo_cnt;
  logic [OFIFO_CNT_W:0]   pending;

  assign in_fire = in_tvalid && in_tready;
  assign is_load = in_fire && (in_tuser == OP_LOAD);
  assign is_hash = in_fire && (in_tuser == OP_HASH);

  // Loads beyond the table are dropped.
  assign load_in_range = (CMP_W'(word_index) < CMP_W'(TABLE_DEPTH));

  // A table_words value above the table depth is taken as the depth.
  assign words_in_use = (CMP_W'(table_words_r) > CMP_W'(TABLE_DEPTH)) ?
                        CMP_W'(TABLE_DEPTH) : CMP_W'(table_words_r);

  // Once a key runs past the words in use, its remaining bytes are ignored.
  assign ovf_now = ovf_r || ((CMP_W'(pos_r) + CMP_W'(BANKS)) > words_in_use);
  assign do_xor  = !ovf_now;

  // The position is always a multiple of eight, so it names a row directly.
  assign rd_row = ROW_W'(pos_r >> BANK_W);

  always_comb begin
    pos_nxt = pos_r;
    ovf_nxt = ovf_r;
    if (is_hash) begin
      if (in_tlast) begin
        pos_nxt = '0;
        ovf_nxt = 1'b0;
      end else begin
        ovf_nxt = ovf_now;
        if (do_xor) begin
          pos_nxt = pos_r + POS_W'(BANKS);
        end
      end
    end
  end

  h3x_tbl #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (STORE_W)
  ) u_tbl (
    .clk     (clk),
    .wr_en   (is_load && load_in_range),
    .wr_addr (IDX_W'(word_index)),
    .wr_data (table_word[STORE_W-1:0]),
    .rd_en   (is_hash && do_xor),
    .rd_row  (rd_row),
    .rd_data (rd_data)
  );

  // XOR of the words picked by the set bits of the byte.
  always_comb begin
    sel_xor = '0;
    for (int k = 0; k < BANKS; k++) begin
      if (s1_byte_r[k]) begin
        sel_xor = sel_xor ^ rd_data[k];
      end
    end
  end

  assign acc_x  = s1_xor_r ? (acc_r ^ sel_xor) : acc_r;
  assign s1_res = s1_valid_r && s1_last_r;

  always_comb begin
    acc_nxt = acc_r;
    if (s1_valid_r) begin
      acc_nxt = s1_last_r ? '0 : acc_x;
    end
  end

  assign push_data.too_long = s1_ovf_r;
  assign push_data.hash     = s1_ovf_r ? '0 : OUT_HASH_W'(acc_x);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_words_r <= '0;
      pos_r         <= '0;
      ovf_r         <= 1'b0;
      acc_r         <= '0;
      s1_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        table_words_r <= cfg_wr_data;
      end
      pos_r      <= pos_nxt;
      ovf_r      <= ovf_nxt;
      acc_r      <= acc_nxt;
      s1_valid_r <= is_hash;
    end
  end

  always_ff @(posedge clk) begin
    if (is_hash) begin
      s1_xor_r  <= do_xor;
      s1_last_r <= in_tlast;
      s1_ovf_r  <= ovf_now;
      s1_byte_r <= data_byte;
    end
  end

  h3x_ofifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_res),
    .push_data (push_data),
    .pop_ready (out_tready),
    .pop_valid (out_tvalid),
    .pop_data  (pop_data),
    .count     (fifo_cnt)
  );

  assign out_tdata = pop_data.hash;
  assign out_tuser = pop_data.too_long;

  // Keep room for the result in flight plus one more.
  assign pending   = (OFIFO_CNT_W+1)'(fifo_cnt) + (OFIFO_CNT_W+1)'(s1_res);
  assign in_tready = (pending < (OFIFO_CNT_W+1)'(OFIFO_DEPTH));

  // The queue always has room when the pipeline hands it a result.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s1_res |-> (fifo_cnt < OFIFO_CNT_W'(OFIFO_DEPTH)))
    else $error("result pushed into a full queue");

  // A last key byte restarts the key.
  a_key_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (is_hash && in_tlast) |=> ((pos_r == '0) && !ovf_r))
    else $error("key state not cleared after last byte");

  // The position never runs past the table.
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (CMP_W'(pos_r) <= CMP_W'(TABLE_DEPTH)))
    else $error("key position beyond table");

  // An overlong key reports a zero hash.
  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("too_long result with non-zero hash");

endmodule

`default_nettype wire
